// ===== rtl/izh_pkg.sv =====
package izh_pkg;

    // Input word layout, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]         pad;
        logic signed [31:0] initial_voltage;
        logic signed [31:0] coef_d;
        logic signed [31:0] coef_c;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_a;
        logic signed [31:0] noise_sample;
        logic signed [31:0] synaptic_sum;
        logic [9:0]         neuron_id;
    } in_data_t;

    // Result word layout, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]         pad;
        logic signed [31:0] recovery_value;
        logic signed [31:0] membrane_voltage;
        logic               in_refractory;
        logic               spiked;
        logic [9:0]         result_index;
    } out_data_t;

    // State store entry: refractory count, recovery value, voltage.
    typedef struct packed {
        logic [15:0]        count;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } st_word_t;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_GAIN    = 3'd0,
        CFG_INPUT_GAIN   = 3'd1,
        CFG_BIAS_CURRENT = 3'd2,
        CFG_NOISE_GAIN   = 3'd3,
        CFG_THRESHOLD    = 3'd4,
        CFG_REFRACTORY   = 3'd5
    } cfg_idx_t;

    // 0.04 in Q16.16 and 140 mV in Q16.16.
    localparam logic [11:0]        Q_004   = 12'd2621;
    localparam logic signed [49:0] C140_Q  = 50'sd9175040;
    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_INIT,
        RES_REFR,
        RES_SPIKE
    } res_op_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_NOISE,
        MUL_VV,
        MUL_SQ,
        MUL_GA,
        MUL_GP,
        MUL_BV,
        MUL_IS,
        MUL_GT
    } mul_sel_t;

    typedef enum logic [3:0] {
        POST_NONE,
        POST_SUM,
        POST_SQ,
        POST_P,
        POST_GA,
        POST_VB,
        POST_T,
        POST_VNEW,
        POST_UNEW
    } post_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_AB,
        ST_INIT_CD,
        ST_RD_AB,
        ST_RD_CD,
        ST_DECIDE,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_WB
    } ctrl_state_t;

    typedef struct packed {
        logic     capture;
        logic     coef_wr;
        logic     coef_rd;
        logic     coef_hi;
        logic     st_rd;
        logic     st_wr;
        logic     latch_state;
        res_op_t  res_op;
        mul_sel_t mul_sel;
        post_op_t post_op;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic in_init;
        logic cur_in_range;
        logic cnt_nonzero;
        logic above_thr;
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [49:0] sext50(input logic signed [31:0] x);
        return {{18{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX)
            r = 32'sh7FFFFFFF;
        else if (x < SAT_MIN)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        return sat32(sext50(x) + sext50(y));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        return sat32(sext50(x) - sext50(y));
    endfunction

    // Floor of the product over 2^16, saturated.
    function automatic logic signed [31:0] qmul_res(input logic signed [65:0] p);
        return sat32(p[65:16]);
    endfunction

endpackage

// ===== rtl/izh_ram.sv =====
module izh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wr_data,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/izh_ctrl.sv =====
module izh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output izh_pkg::dp_cmd_t  cmd,
    input  izh_pkg::dp_stat_t stat
);

    izh_pkg::ctrl_state_t state_reg;
    izh_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= izh_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            izh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (!stat.in_range)
                        state_next = izh_pkg::ST_WB;
                    else if (stat.in_init)
                        state_next = izh_pkg::ST_INIT_AB;
                    else
                        state_next = izh_pkg::ST_RD_AB;
                end
            end
            izh_pkg::ST_INIT_AB: state_next = izh_pkg::ST_INIT_CD;
            izh_pkg::ST_INIT_CD: state_next = izh_pkg::ST_WB;
            izh_pkg::ST_RD_AB:   state_next = izh_pkg::ST_RD_CD;
            izh_pkg::ST_RD_CD:   state_next = izh_pkg::ST_DECIDE;
            izh_pkg::ST_DECIDE:
            begin
                if (stat.cnt_nonzero || stat.above_thr)
                    state_next = izh_pkg::ST_WB;
                else
                    state_next = izh_pkg::ST_M1;
            end
            izh_pkg::ST_M1: state_next = izh_pkg::ST_M2;
            izh_pkg::ST_M2: state_next = izh_pkg::ST_M3;
            izh_pkg::ST_M3: state_next = izh_pkg::ST_M4;
            izh_pkg::ST_M4: state_next = izh_pkg::ST_M5;
            izh_pkg::ST_M5: state_next = izh_pkg::ST_M6;
            izh_pkg::ST_M6: state_next = izh_pkg::ST_M7;
            izh_pkg::ST_M7: state_next = izh_pkg::ST_M8;
            izh_pkg::ST_M8: state_next = izh_pkg::ST_WB;
            izh_pkg::ST_WB:
            begin
                if (stat.out_free)
                    state_next = izh_pkg::ST_IDLE;
            end
            default: state_next = izh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.res_op  = izh_pkg::RES_NONE;
        cmd.mul_sel = izh_pkg::MUL_NONE;
        cmd.post_op = izh_pkg::POST_NONE;
        in_ready    = 1'b0;
        unique case (state_reg)
            izh_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            izh_pkg::ST_INIT_AB:
            begin
                cmd.coef_wr = 1'b1;
            end
            izh_pkg::ST_INIT_CD:
            begin
                cmd.coef_wr = 1'b1;
                cmd.coef_hi = 1'b1;
                cmd.res_op  = izh_pkg::RES_INIT;
            end
            izh_pkg::ST_RD_AB:
            begin
                cmd.st_rd   = 1'b1;
                cmd.coef_rd = 1'b1;
            end
            izh_pkg::ST_RD_CD:
            begin
                cmd.coef_rd     = 1'b1;
                cmd.coef_hi     = 1'b1;
                cmd.latch_state = 1'b1;
            end
            izh_pkg::ST_DECIDE:
            begin
                priority if (stat.cnt_nonzero)
                    cmd.res_op = izh_pkg::RES_REFR;
                else if (stat.above_thr)
                    cmd.res_op = izh_pkg::RES_SPIKE;
                else
                    cmd.res_op = izh_pkg::RES_NONE;
                cmd.mul_sel = izh_pkg::MUL_NOISE;
            end
            izh_pkg::ST_M1:
            begin
                cmd.post_op = izh_pkg::POST_SUM;
                cmd.mul_sel = izh_pkg::MUL_VV;
            end
            izh_pkg::ST_M2:
            begin
                cmd.post_op = izh_pkg::POST_SQ;
                cmd.mul_sel = izh_pkg::MUL_SQ;
            end
            izh_pkg::ST_M3:
            begin
                cmd.post_op = izh_pkg::POST_P;
                cmd.mul_sel = izh_pkg::MUL_GA;
            end
            izh_pkg::ST_M4:
            begin
                cmd.post_op = izh_pkg::POST_GA;
                cmd.mul_sel = izh_pkg::MUL_GP;
            end
            izh_pkg::ST_M5:
            begin
                cmd.post_op = izh_pkg::POST_VB;
                cmd.mul_sel = izh_pkg::MUL_BV;
            end
            izh_pkg::ST_M6:
            begin
                cmd.post_op = izh_pkg::POST_T;
                cmd.mul_sel = izh_pkg::MUL_IS;
            end
            izh_pkg::ST_M7:
            begin
                cmd.post_op = izh_pkg::POST_VNEW;
                cmd.mul_sel = izh_pkg::MUL_GT;
            end
            izh_pkg::ST_M8:
            begin
                cmd.post_op = izh_pkg::POST_UNEW;
            end
            izh_pkg::ST_WB:
            begin
                cmd.st_wr    = stat.out_free && stat.cur_in_range;
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_capture_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == izh_pkg::ST_IDLE && in_valid) |=> state_reg != izh_pkg::ST_IDLE)
        else $error("accepted word did not start processing");

    a_wb_holds_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == izh_pkg::ST_WB && !stat.out_free) |=> state_reg == izh_pkg::ST_WB)
        else $error("writeback left while result slot was occupied");

    a_ready_only_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == izh_pkg::ST_IDLE)
        else $error("input ready outside the idle state");
`endif

endmodule

// ===== rtl/izh_datapath.sv =====
module izh_datapath #(
    parameter int NEURONS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [izh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    input  izh_pkg::in_data_t               in_data,
    input  logic                            in_opcode,
    output izh_pkg::out_data_t              out_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    input  izh_pkg::dp_cmd_t                cmd,
    output izh_pkg::dp_stat_t               stat
);

    localparam int AW  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int CAW = $clog2(2 * NEURONS);

    // Configuration registers.
    logic [30:0]        step_gain_reg;
    logic signed [31:0] input_gain_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] noise_gain_reg;
    logic signed [31:0] threshold_reg;
    logic [15:0]        refr_steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_gain_reg  <= 31'd6554;
            input_gain_reg <= '0;
            bias_reg       <= '0;
            noise_gain_reg <= '0;
            threshold_reg  <= 32'sd1966080;
            refr_steps_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                izh_pkg::CFG_STEP_GAIN:    step_gain_reg  <= cfg_data[30:0];
                izh_pkg::CFG_INPUT_GAIN:   input_gain_reg <= cfg_data;
                izh_pkg::CFG_BIAS_CURRENT: bias_reg       <= cfg_data;
                izh_pkg::CFG_NOISE_GAIN:   noise_gain_reg <= cfg_data;
                izh_pkg::CFG_THRESHOLD:    threshold_reg  <= cfg_data;
                izh_pkg::CFG_REFRACTORY:   refr_steps_reg <= cfg_data[15:0];
                default:                   ;
            endcase
        end
    end

    // Captured item.
    logic [9:0]         idx_reg;
    logic signed [31:0] syn_reg;
    logic signed [31:0] noise_reg;
    logic signed [31:0] ca_reg;
    logic signed [31:0] cb_reg;
    logic signed [31:0] cc_reg;
    logic signed [31:0] cd_reg;
    logic signed [31:0] civ_reg;
    logic               range_reg;
    logic               in_range_now;

    assign in_range_now = {7'b0, in_data.neuron_id} < 17'(NEURONS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            range_reg <= in_range_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg   <= in_data.neuron_id;
            syn_reg   <= in_data.synaptic_sum;
            noise_reg <= in_data.noise_sample;
            ca_reg    <= in_data.coef_a;
            cb_reg    <= in_data.coef_b;
            cc_reg    <= in_data.coef_c;
            cd_reg    <= in_data.coef_d;
            civ_reg   <= in_data.initial_voltage;
        end
    end

    // Neuron stores. Coefficient entry 2n holds {b, a}, entry 2n+1 holds {d, c}.
    logic [16:0]         idx_ext;
    logic [AW-1:0]       st_addr;
    logic [CAW-1:0]      coef_addr;
    logic [63:0]         coef_wr_data;
    logic [63:0]         coef_rd_data;
    izh_pkg::st_word_t   st_wr_data;
    izh_pkg::st_word_t   st_rd_data;

    logic signed [31:0] vout_reg;
    logic signed [31:0] uout_reg;
    logic [15:0]        cnt_new_reg;
    logic               spk_reg;
    logic               refr_reg;

    assign idx_ext      = {7'b0, idx_reg};
    assign st_addr      = AW'(idx_ext);
    assign coef_addr    = CAW'({idx_ext, cmd.coef_hi});
    assign coef_wr_data = cmd.coef_hi ? {cd_reg, cc_reg} : {cb_reg, ca_reg};
    assign st_wr_data   = '{count: cnt_new_reg, u: uout_reg, v: vout_reg};

    izh_ram #(
        .WIDTH (80),
        .DEPTH (NEURONS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (cmd.st_wr),
        .rd_en   (cmd.st_rd),
        .addr    (st_addr),
        .wr_data (st_wr_data),
        .rd_data (st_rd_data)
    );

    izh_ram #(
        .WIDTH (64),
        .DEPTH (2 * NEURONS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (cmd.coef_wr),
        .rd_en   (cmd.coef_rd),
        .addr    (coef_addr),
        .wr_data (coef_wr_data),
        .rd_data (coef_rd_data)
    );

    // Working copy of the neuron.
    logic signed [31:0] v_reg;
    logic signed [31:0] u_reg;
    logic [15:0]        cnt_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_state)
        begin
            v_reg   <= st_rd_data.v;
            u_reg   <= st_rd_data.u;
            cnt_reg <= st_rd_data.count;
            a_reg   <= coef_rd_data[31:0];
            b_reg   <= coef_rd_data[63:32];
        end
    end

    // Shared multiplier with registered product.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;
    logic signed [65:0] prod_reg;

    logic signed [31:0] sum_reg;
    logic [15:0]        lo_reg;
    logic signed [37:0] k_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] ga_reg;
    logic signed [31:0] vb_reg;
    logic signed [31:0] t_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            izh_pkg::MUL_NOISE:
            begin
                mul_a = {noise_reg[31], noise_reg};
                mul_b = {noise_gain_reg[31], noise_gain_reg};
            end
            izh_pkg::MUL_VV:
            begin
                mul_a = {v_reg[31], v_reg};
                mul_b = {v_reg[31], v_reg};
            end
            izh_pkg::MUL_SQ:
            begin
                // Upper part of the squared voltage times 0.04.
                mul_a = {2'b00, prod_reg[62:32]};
                mul_b = {21'b0, izh_pkg::Q_004};
            end
            izh_pkg::MUL_GA:
            begin
                mul_a = {2'b00, step_gain_reg};
                mul_b = {a_reg[31], a_reg};
            end
            izh_pkg::MUL_GP:
            begin
                mul_a = {2'b00, step_gain_reg};
                mul_b = {p_reg[31], p_reg};
            end
            izh_pkg::MUL_BV:
            begin
                mul_a = {b_reg[31], b_reg};
                mul_b = {v_reg[31], v_reg};
            end
            izh_pkg::MUL_IS:
            begin
                mul_a = {input_gain_reg[31], input_gain_reg};
                mul_b = {sum_reg[31], sum_reg};
            end
            izh_pkg::MUL_GT:
            begin
                mul_a = {ga_reg[31], ga_reg};
                mul_b = {t_reg[31], t_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != izh_pkg::MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
    end

    logic signed [31:0] qm;
    logic signed [49:0] k_next;
    logic [27:0]        lo_prod;
    logic signed [49:0] p_sum;

    assign qm      = izh_pkg::qmul_res(prod_reg);
    assign k_next  = (izh_pkg::sext50(v_reg) <<< 2) + izh_pkg::sext50(v_reg)
                     + izh_pkg::C140_Q - izh_pkg::sext50(u_reg);
    assign lo_prod = 28'(lo_reg) * 28'(izh_pkg::Q_004);
    // The upper product is below 2^43, so its low bits carry it whole.
    assign p_sum   = $signed({6'b0, prod_reg[43:0]}) + $signed({38'b0, lo_prod[27:16]})
                     + $signed({{12{k_reg[37]}}, k_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vout_reg    <= '0;
            uout_reg    <= '0;
            cnt_new_reg <= '0;
            spk_reg     <= 1'b0;
            refr_reg    <= 1'b0;
        end

        unique case (cmd.res_op)
            izh_pkg::RES_INIT:
            begin
                vout_reg    <= civ_reg;
                uout_reg    <= '0;
                cnt_new_reg <= '0;
            end
            izh_pkg::RES_REFR:
            begin
                vout_reg    <= v_reg;
                uout_reg    <= u_reg;
                cnt_new_reg <= cnt_reg - 16'd1;
                refr_reg    <= 1'b1;
            end
            izh_pkg::RES_SPIKE:
            begin
                vout_reg    <= coef_rd_data[31:0];
                uout_reg    <= izh_pkg::qadd(u_reg, coef_rd_data[63:32]);
                cnt_new_reg <= refr_steps_reg;
                spk_reg     <= 1'b1;
            end
            default: ;
        endcase

        unique case (cmd.post_op)
            izh_pkg::POST_SUM:  sum_reg  <= izh_pkg::qadd(izh_pkg::qadd(syn_reg, bias_reg), qm);
            izh_pkg::POST_SQ:
            begin
                lo_reg <= prod_reg[31:16];
                k_reg  <= k_next[37:0];
            end
            izh_pkg::POST_P:    p_reg    <= izh_pkg::sat32(p_sum);
            izh_pkg::POST_GA:   ga_reg   <= qm;
            izh_pkg::POST_VB:   vb_reg   <= izh_pkg::qadd(v_reg, qm);
            izh_pkg::POST_T:    t_reg    <= izh_pkg::qsub(qm, u_reg);
            izh_pkg::POST_VNEW: vout_reg <= izh_pkg::qadd(vb_reg, qm);
            izh_pkg::POST_UNEW: uout_reg <= izh_pkg::qadd(u_reg, qm);
            default: ;
        endcase
    end

    // Result register.
    logic               out_valid_reg;
    izh_pkg::out_data_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg.pad              <= '0;
            out_data_reg.recovery_value   <= uout_reg;
            out_data_reg.membrane_voltage <= vout_reg;
            out_data_reg.in_refractory    <= refr_reg;
            out_data_reg.spiked           <= spk_reg;
            out_data_reg.result_index     <= idx_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.in_range     = in_range_now;
    assign stat.in_init      = in_opcode;
    assign stat.cur_in_range = range_reg;
    assign stat.cnt_nonzero  = cnt_reg != 16'd0;
    assign stat.above_thr    = v_reg >= threshold_reg;
    assign stat.out_free     = !out_valid_reg || out_ready;

`ifndef ASSERT_OFF
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

    a_state_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.st_wr |-> range_reg)
        else $error("state store written for an out-of-range neuron");

    a_coef_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coef_wr |-> (range_reg && !cmd.st_rd && !cmd.coef_rd))
        else $error("coefficient write outside an in-range init");
`endif

endmodule

// ===== rtl/izhikevich_neuron_update_top.sv =====
// Izhikevich neuron table. Each item on the slave stream addresses one neuron.
// s_axis_tuser carries the opcode: 0 advances the neuron one step, 1 loads
// its coefficients and starting voltage and clears its recovery value and
// refractory count. Every accepted word produces exactly one result word on
// the master stream, in order. Configuration registers are written over the
// cfg channel while the block is idle; the user must keep to this, as the
// block itself does not enforce it. cfg_ready is always high. Items are
// processed one at a time around a single shared 33x33 multiplier and two
// single-port neuron stores. The result word is loaded into the output
// register in writeback: for an integration step after the store reads, the
// decision and the eight chained multiplies; for a refractory or spiking
// step straight after the decision; for an init after the coefficient
// writes; for an index beyond the table straight from idle. The next word
// is accepted the cycle after the result is loaded. The result sits in an
// output register, so the next word is accepted while it waits; if the
// receiver still stalls when the following result is ready, the block
// holds in writeback until the register frees up. Reset clears the control
// state and loads the default register values; the neuron stores are not
// cleared, and a neuron must be initialized before it is advanced.
module izhikevich_neuron_update_top #(
    parameter int NEURONS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Fields from bit 0: neuron_id[9:0], synaptic_sum[41:10],
    // noise_sample[73:42], coef_a[105:74], coef_b[137:106], coef_c[169:138],
    // coef_d[201:170], initial_voltage[233:202], zero fill to 240 bits.
    input  logic [239:0]                  s_axis_tdata,
    // Fields from bit 0: opcode[0].
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,

    // Fields from bit 0: result_index[9:0], spiked[10], in_refractory[11],
    // membrane_voltage[43:12], recovery_value[75:44], zero fill to 80 bits.
    output logic [79:0]                   m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [izh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    izh_pkg::dp_cmd_t   cmd;
    izh_pkg::dp_stat_t  stat;
    izh_pkg::in_data_t  in_word;
    izh_pkg::out_data_t out_word;

    // Register writes take effect on the handshake edge.
    assign cfg_ready    = 1'b1;
    assign in_word      = s_axis_tdata;
    assign m_axis_tdata = out_word;

    izh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    izh_datapath #(
        .NEURONS (NEURONS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_word),
        .in_opcode (s_axis_tuser),
        .out_data  (out_word),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== tb/izhikevich_neuron_update_top_tb.sv =====
`timescale 1ns / 1ps

module izhikevich_neuron_update_top_tb;

    // Opcode carried on s_axis_tuser.
    typedef enum bit {
        OP_STEP = 1'b0,
        OP_INIT = 1'b1
    } op_t;

    localparam int     NEURONS   = 1024;
    localparam int     MV        = 65536;      // one millivolt in Q16.16
    localparam longint POINT04_Q = 2621;       // 0.04 in Q16.16
    localparam longint REST_Q    = 140 * 65536;
    localparam longint I32_MAX   = 64'sd2147483647;
    localparam longint I32_MIN   = -64'sd2147483648;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Block ports. Every input holds a known value from time zero.
    logic [239:0]                  s_axis_tdata  = '0;
    logic                          s_axis_tuser  = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [79:0]                   m_axis_tdata;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b1;
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [izh_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [31:0]                   cfg_data      = '0;

    izhikevich_neuron_update_top #(
        .NEURONS(NEURONS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Our own copy of the register file, kept at reset values until written.
    longint    cfg_step_gain  = 6554;
    longint    cfg_input_gain = 0;
    longint    cfg_bias       = 0;
    longint    cfg_noise_gain = 0;
    longint    cfg_threshold  = 1966080;
    bit [15:0] cfg_refr_steps = 16'd0;

    // Our own copy of the neuron table. The flags track which neurons were
    // initialized, so that a step is never sent to a neuron still undefined.
    int        volt_mem   [NEURONS];
    int        recov_mem  [NEURONS];
    bit [15:0] count_mem  [NEURONS];
    int        coef_a_mem [NEURONS];
    int        coef_b_mem [NEURONS];
    int        coef_c_mem [NEURONS];
    int        coef_d_mem [NEURONS];
    bit        loaded     [NEURONS];

    izh_pkg::out_data_t pending_results[$];
    int                 mismatch_count = 0;

    // When set, both sides of the stream throw in random idle cycles.
    bit        stall_on = 1'b1;

    // Neurons that the random part keeps coming back to, so that voltages
    // evolve over many steps and reach spikes and refractory runs.
    int        hot_neurons[8];

    // ------------------------------------------------------------------
    // Fixed point helpers: saturate to 32 bits, floor of product / 2^16.
    // ------------------------------------------------------------------
    function automatic longint clamp32(input longint x);
        if (x > I32_MAX)
            return I32_MAX;
        if (x < I32_MIN)
            return I32_MIN;
        return x;
    endfunction

    function automatic longint fx_mul(input longint x, input longint y);
        return clamp32((x * y) >>> 16);
    endfunction

    function automatic longint fx_add(input longint x, input longint y);
        return clamp32(x + y);
    endfunction

    function automatic longint fx_sub(input longint x, input longint y);
        return clamp32(x - y);
    endfunction

    // Applies one accepted word to the shadow table and returns the result
    // word that the block must produce for it.
    function automatic izh_pkg::out_data_t advance_neuron(input op_t op,
                                                          input izh_pkg::in_data_t w);
        izh_pkg::out_data_t r;
        int                 n;
        longint             v, u, a, b, sum, sq, p, vb, vout, uout;
        r              = '0;
        n              = int'(w.neuron_id);
        r.result_index = w.neuron_id;
        if (op == OP_INIT)
        begin
            coef_a_mem[n] = w.coef_a;
            coef_b_mem[n] = w.coef_b;
            coef_c_mem[n] = w.coef_c;
            coef_d_mem[n] = w.coef_d;
            volt_mem[n]   = w.initial_voltage;
            recov_mem[n]  = 0;
            count_mem[n]  = 16'd0;
            loaded[n]     = 1'b1;
            r.membrane_voltage = w.initial_voltage;
            r.recovery_value   = '0;
            return r;
        end
        v = longint'(volt_mem[n]);
        u = longint'(recov_mem[n]);
        if (count_mem[n] != 16'd0)
        begin
            // Refractory: count down, voltage and recovery stay put.
            count_mem[n]    = count_mem[n] - 16'd1;
            r.in_refractory = 1'b1;
            vout = v;
            uout = u;
        end
        else if (v >= cfg_threshold)
        begin
            // Spike: reset to c, bump recovery by d, reload the count.
            vout         = longint'(coef_c_mem[n]);
            uout         = fx_add(u, longint'(coef_d_mem[n]));
            count_mem[n] = cfg_refr_steps;
            r.spiked     = 1'b1;
        end
        else
        begin
            // One Euler step of the membrane and recovery equations.
            a    = longint'(coef_a_mem[n]);
            b    = longint'(coef_b_mem[n]);
            sum  = fx_add(fx_add(longint'(w.synaptic_sum), cfg_bias),
                          fx_mul(longint'(w.noise_sample), cfg_noise_gain));
            sq   = (v * v) >>> 16;
            p    = clamp32(((sq * POINT04_Q) >>> 16) + 5 * v + REST_Q - u);
            vb   = fx_add(v, fx_mul(cfg_step_gain, p));
            uout = fx_add(u, fx_mul(fx_mul(cfg_step_gain, a), fx_sub(fx_mul(b, v), u)));
            vout = fx_add(vb, fx_mul(cfg_input_gain, sum));
        end
        volt_mem[n]        = int'(vout);
        recov_mem[n]       = int'(uout);
        r.membrane_voltage = 32'(vout);
        r.recovery_value   = 32'(uout);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking. Each accepted result word is compared with the
    // oldest expectation, field by field.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch in %s, got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    izh_pkg::out_data_t seen_word;
    izh_pkg::out_data_t want_word;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_word = m_axis_tdata;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected",
                                32'(seen_word.result_index), '0);
            else
            begin
                want_word = pending_results.pop_front();
                if (seen_word.result_index !== want_word.result_index)
                    report_mismatch("result_index", 32'(seen_word.result_index),
                                    32'(want_word.result_index));
                if (seen_word.spiked !== want_word.spiked)
                    report_mismatch("spiked", 32'(seen_word.spiked),
                                    32'(want_word.spiked));
                if (seen_word.in_refractory !== want_word.in_refractory)
                    report_mismatch("in_refractory", 32'(seen_word.in_refractory),
                                    32'(want_word.in_refractory));
                if (seen_word.membrane_voltage !== want_word.membrane_voltage)
                    report_mismatch("membrane_voltage", seen_word.membrane_voltage,
                                    want_word.membrane_voltage);
                if (seen_word.recovery_value !== want_word.recovery_value)
                    report_mismatch("recovery_value", seen_word.recovery_value,
                                    want_word.recovery_value);
            end
        end
    end

    // The receiver drops ready about 18 percent of the time while stalling is on.
    always @(negedge clk)
        m_axis_tready <= stall_on ? ($urandom_range(99) >= 18) : 1'b1;

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic izh_pkg::in_data_t make_word(input int n, input int syn,
                                                    input int noise, input int a,
                                                    input int b, input int c,
                                                    input int d, input int v0);
        izh_pkg::in_data_t w;
        w                 = '0;
        w.neuron_id       = n[9:0];
        w.synaptic_sum    = syn;
        w.noise_sample    = noise;
        w.coef_a          = a;
        w.coef_b          = b;
        w.coef_c          = c;
        w.coef_d          = d;
        w.initial_voltage = v0;
        return w;
    endfunction

    // Sends one word on the slave stream, with an occasional idle gap in
    // front of it, and records its expected result once it is accepted.
    task automatic send_word(input op_t op, input izh_pkg::in_data_t w);
        while (stall_on && ($urandom_range(99) < 18))
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(advance_neuron(op, w));
    endtask

    task automatic init_neuron(input int n, input int a, input int b, input int c,
                               input int d, input int v0);
        send_word(OP_INIT, make_word(n, $urandom, $urandom, a, b, c, d, v0));
    endtask

    task automatic step_neuron(input int n, input int syn, input int noise);
        send_word(OP_STEP, make_word(n, syn, noise, $urandom, $urandom, $urandom,
                                     $urandom, $urandom));
    endtask

    // Stops the stream and waits until every expected result has come back,
    // then lets the block settle for a while longer.
    task automatic drain_results(input int settle_cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle_cycles)
            @(posedge clk);
    endtask

    // One write on the configuration channel. The valid stays high when the
    // caller follows with another write; set_config lowers it at the end.
    task automatic write_reg(input izh_pkg::cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            izh_pkg::CFG_STEP_GAIN:    cfg_step_gain  = longint'({1'b0, val[30:0]});
            izh_pkg::CFG_INPUT_GAIN:   cfg_input_gain = longint'($signed(val));
            izh_pkg::CFG_BIAS_CURRENT: cfg_bias       = longint'($signed(val));
            izh_pkg::CFG_NOISE_GAIN:   cfg_noise_gain = longint'($signed(val));
            izh_pkg::CFG_THRESHOLD:    cfg_threshold  = longint'($signed(val));
            izh_pkg::CFG_REFRACTORY:   cfg_refr_steps = val[15:0];
            default:                   ;
        endcase
    endtask

    // Rewrites the whole register file once the block has gone idle.
    task automatic set_config(input logic [31:0] step_gain, input logic [31:0] input_gain,
                              input logic [31:0] bias, input logic [31:0] noise_gain,
                              input logic [31:0] threshold, input logic [31:0] refr_steps);
        drain_results(16);
        write_reg(izh_pkg::CFG_STEP_GAIN, step_gain);
        write_reg(izh_pkg::CFG_INPUT_GAIN, input_gain);
        write_reg(izh_pkg::CFG_BIAS_CURRENT, bias);
        write_reg(izh_pkg::CFG_NOISE_GAIN, noise_gain);
        write_reg(izh_pkg::CFG_THRESHOLD, threshold);
        write_reg(izh_pkg::CFG_REFRACTORY, refr_steps);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random word. Most words carry plausible neuron values so that the
    // dynamics reach spikes and refractory runs; a quarter carry raw bits.
    task automatic send_random_word();
        int  n;
        bit  wild;
        op_t op;
        if ($urandom_range(99) < 80)
            n = hot_neurons[$urandom_range(7)];
        else
            n = $urandom_range(NEURONS - 1);
        wild = ($urandom_range(99) < 25);
        op   = (!loaded[n] || ($urandom_range(99) < 10)) ? OP_INIT : OP_STEP;
        if (op == OP_INIT)
        begin
            if (wild)
                init_neuron(n, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                init_neuron(n, rand_between(1000, 7000), rand_between(10000, 17000),
                            rand_between(-70 * MV, -50 * MV), rand_between(0, 8 * MV),
                            rand_between(-80 * MV, 35 * MV));
        end
        else
        begin
            if (wild)
                step_neuron(n, $urandom, $urandom);
            else
                step_neuron(n, rand_between(-5 * MV, 60 * MV),
                            rand_between(-3 * MV, 3 * MV));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Register values straight out of reset: plain dynamics with no input,
    // and the table corners with extreme voltages and coefficients.
    task automatic test_reset_defaults();
        init_neuron(0, 1311, 13107, -65 * MV, 8 * MV, -65 * MV);
        step_neuron(0, 10 * MV, MV);
        step_neuron(0, 10 * MV, MV);
        // Top of the voltage range fires at once; the reset voltage is the
        // most negative value, so the next step saturates all the way.
        init_neuron(NEURONS - 1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                    32'h7FFFFFFF, 32'h7FFFFFFF);
        step_neuron(NEURONS - 1, 32'h7FFFFFFF, 32'h80000000);
        step_neuron(NEURONS - 1, 32'h80000000, 32'h7FFFFFFF);
    endtask

    // Firing exactly at threshold, the refractory countdown, and an init
    // that lands in the middle of a refractory run and clears it.
    task automatic test_spike_and_refractory();
        set_config(32'd6554, 32'd13107, 32'd65536, 32'd6554, 32'd30 * MV, 32'd2);
        init_neuron(5, 1311, 13107, -65 * MV, 8 * MV, 30 * MV);
        step_neuron(5, 0, 0);
        step_neuron(5, 0, 0);
        step_neuron(5, 0, 0);
        step_neuron(5, 20 * MV, -MV);
        init_neuron(5, 1311, 13107, -60 * MV, 2 * MV, 50 * MV);
        step_neuron(5, 0, 0);
        step_neuron(5, 0, 0);
        init_neuron(5, 1311, 13107, -65 * MV, 8 * MV, -70 * MV);
        step_neuron(5, 5 * MV, 0);
    endtask

    // Every register at its top and then at its bottom value, with the
    // input fields pushed to their extremes.
    task automatic test_register_extremes();
        set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 32'h0000FFFF);
        init_neuron(2, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 32'h80000000);
        step_neuron(2, 32'h7FFFFFFF, 32'h7FFFFFFF);
        step_neuron(2, 32'h80000000, 32'h80000000);
        init_neuron(3, 1311, 13107, -65 * MV, 8 * MV, 32'h7FFFFFFF);
        step_neuron(3, 0, 0);
        step_neuron(3, 0, 0);
        set_config(32'h00000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h00000000);
        step_neuron(2, 32'h80000000, 32'h7FFFFFFF);
        init_neuron(3, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    32'h80000000);
        step_neuron(3, 0, 0);
    endtask

    // Random words over eight phases and six register settings. One phase
    // runs with no idling at all on either side.
    task automatic test_random_phases();
        int ph;
        for (int k = 0; k < 8; k++)
            hot_neurons[k] = $urandom_range(NEURONS - 1);
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0, 1, 7:
                    set_config(32'd6554, 32'd13107, 32'd65536, 32'd3277,
                               32'd30 * MV, 32'd3);
                2:
                    set_config($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom_range(5));
                3:
                    set_config(32'd13107, 32'd19661, 32'd0, 32'd6554,
                               32'd30 * MV, 32'd0);
                4:
                    set_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               32'h7FFFFFFF, 32'h0000FFFF);
                5:
                    set_config(32'h00000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h00000000);
                default:
                    set_config($urandom_range(65536), rand_between(-65536, 65536),
                               rand_between(-5 * MV, 5 * MV), rand_between(-65536, 65536),
                               rand_between(-80 * MV, 40 * MV), $urandom_range(10));
            endcase
            stall_on = (ph != 1);
            repeat (95)
                send_random_word();
        end
        stall_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_spike_and_refractory();
        test_register_extremes();
        test_random_phases();

        drain_results(30);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
